// ----- rtl/core/bkre_pkg.sv -----
// Package for the boot keyboard report decoder.
// Holds the event word type, register and key constants, and the US key map.
// No dependencies.
package bkre_pkg;

	// Register indexes of the configuration port.
	localparam logic REG_ENTER_LF = 1'b0;

	// Key codes and masks.
	localparam logic [7:0] KEY_LOWEST  = 8'h04;
	localparam logic [7:0] SHIFT_MASK  = 8'h22;
	localparam logic [6:0] CHAR_CR     = 7'h0D;

	// One decoded key event word.
	typedef struct packed {
		logic       is_press;
		logic [7:0] key;
		logic [7:0] mods;
		logic [6:0] char_code;
		logic       char_valid;
		logic       lf_follows;
		logic       last;
	} bkre_event_t;

	// US layout lookup for usage codes 4 to 0x38; everything else gives zero.
	function automatic logic [6:0] char_lookup(input logic [7:0] code, input logic shifted);
		logic [6:0] ch;
		ch = 7'h00;
		case (code) inside
			[8'h04:8'h1D]: begin
				ch = shifted ? 7'(code + 8'h3D) : 7'(code + 8'h5D);
			end
			[8'h1E:8'h26]: begin
				if (!shifted) begin
					ch = 7'(code + 8'h13);
				end else begin
					case (code)
						8'h1E:   ch = 7'h21;
						8'h1F:   ch = 7'h40;
						8'h20:   ch = 7'h23;
						8'h21:   ch = 7'h24;
						8'h22:   ch = 7'h25;
						8'h23:   ch = 7'h5E;
						8'h24:   ch = 7'h26;
						8'h25:   ch = 7'h2A;
						default: ch = 7'h28;
					endcase
				end
			end
			8'h27:        ch = shifted ? 7'h29 : 7'h30;
			8'h28:        ch = CHAR_CR;
			8'h2A:        ch = shifted ? 7'h00 : 7'h08;
			8'h2C:        ch = 7'h20;
			8'h2D:        ch = shifted ? 7'h5F : 7'h2D;
			8'h2E:        ch = shifted ? 7'h2B : 7'h3D;
			8'h2F:        ch = shifted ? 7'h7B : 7'h5B;
			8'h30:        ch = shifted ? 7'h7D : 7'h5D;
			8'h31, 8'h32: ch = shifted ? 7'h7C : 7'h5C;
			8'h33:        ch = shifted ? 7'h3A : 7'h3B;
			8'h34:        ch = shifted ? 7'h22 : 7'h27;
			8'h35:        ch = shifted ? 7'h7E : 7'h60;
			8'h36:        ch = shifted ? 7'h3C : 7'h2C;
			8'h37:        ch = shifted ? 7'h3E : 7'h2E;
			8'h38:        ch = shifted ? 7'h3F : 7'h2F;
			default:      ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/core/bkre_front.sv -----
// Front end of the report decoder: compares each report with the stored one.
// Produces release and press masks and the queue word. Depends on bkre_pkg.
module bkre_front import bkre_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        too_short,
	input  logic [7:0]                  modifier_bits,
	input  logic [8*KEY_SLOTS-1:0]      now_keys,
	input  logic                        q_full,
	output logic                        q_push,
	output logic [18*KEY_SLOTS+7:0]     q_wdata
);

	logic [8*KEY_SLOTS-1:0] prev_q;
	logic [KEY_SLOTS-1:0]   rel;
	logic [KEY_SLOTS-1:0]   prs;
	logic                   take;

	// Release when an old key is gone, press when a new key was not there.
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			logic old_seen;
			logic new_seen;
			old_seen = 1'b0;
			new_seen = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (now_keys[8*j +: 8] == prev_q[8*i +: 8]) old_seen = 1'b1;
				if (prev_q[8*j +: 8] == now_keys[8*i +: 8]) new_seen = 1'b1;
			end
			rel[i] = (prev_q[8*i +: 8] >= KEY_LOWEST) && !old_seen;
			prs[i] = (now_keys[8*i +: 8] >= KEY_LOWEST) && !new_seen;
		end
	end

	// A full report is taken whenever the queue has room; only changes are queued.
	assign take    = push && !q_full && !too_short;
	assign q_push  = take && ((|rel) || (|prs));
	assign q_wdata = {modifier_bits, now_keys, prev_q, prs, rel};

	// Stored key slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (take) begin
			prev_q <= now_keys;
		end
	end

endmodule

// ----- rtl/core/bkre_fifo.sv -----
// Short queue between the front end and the event sequencer.
// Generic register queue; no package dependencies.
module bkre_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/bkre_back.sv -----
// Back end of the report decoder: walks queued masks, one word a cycle unless stalled.
// Translates presses to characters and holds the output register. Depends on bkre_pkg.
module bkre_back import bkre_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [18*KEY_SLOTS+7:0] q_rdata,
	input  logic                    q_empty,
	output logic                    q_pop,
	input  logic                    lf_enable,
	input  logic                    out_pop,
	output logic                    out_valid,
	output bkre_event_t             out_event
);

	localparam int PEND_W = 2 * KEY_SLOTS;
	localparam int SW     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int IW     = SW + 1;
	localparam int KW     = 8 * KEY_SLOTS;

	logic [PEND_W-1:0] pend_q;
	logic [KW-1:0]     now_q;
	logic [KW-1:0]     old_q;
	logic [7:0]        mods_q;
	logic              out_v_q;
	bkre_event_t       out_q;

	logic [PEND_W-1:0]    pend_load;
	logic [PEND_W-1:0]    lowest;
	logic [IW-1:0]        idx;
	logic [SW-1:0]        slot;
	logic                 press;
	logic                 fire;
	logic                 last;
	logic                 shifted;
	bkre_event_t          ev;

	// Interleave the masks so that a slot's release comes before its press.
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			pend_load[2*i]     = q_rdata[i];
			pend_load[2*i + 1] = q_rdata[KEY_SLOTS + i];
		end
	end

	// Pick the lowest pending event and encode its position.
	always_comb begin
		lowest = pend_q & (~pend_q + PEND_W'(1));
		idx    = '0;
		for (int j = 0; j < PEND_W; j++) begin
			if (lowest[j]) idx = idx | IW'(j);
		end
	end

	assign slot    = idx[IW-1:1];
	assign press   = idx[0];
	assign shifted = |(mods_q & SHIFT_MASK);
	assign last    = ((pend_q & ~lowest) == '0);
	assign fire    = (|pend_q) && (!out_v_q || out_pop);
	assign q_pop   = !q_empty && ((pend_q == '0) || (fire && last));

	// Build the event word.
	always_comb begin
		ev.is_press   = press;
		ev.key        = press ? now_q[8*slot +: 8] : old_q[8*slot +: 8];
		ev.mods       = press ? mods_q : 8'h00;
		ev.char_code  = press ? char_lookup(ev.key, shifted) : 7'h00;
		ev.char_valid = (ev.char_code != 7'h00);
		ev.lf_follows = ev.char_valid && (ev.char_code == CHAR_CR) && lf_enable;
		ev.last       = last;
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				pend_q <= pend_load;
			end else if (fire) begin
				pend_q <= pend_q & ~lowest;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (out_pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Current report and output word.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			mods_q <= q_rdata[18*KEY_SLOTS +: 8];
			now_q  <= q_rdata[2*KEY_SLOTS + KW +: KW];
			old_q  <= q_rdata[2*KEY_SLOTS +: KW];
		end
		if (fire) begin
			out_q <= ev;
		end
	end

	assign out_valid = out_v_q;
	assign out_event = out_q;

endmodule

// ----- rtl/core/boot_keyboard_report_to_key_events_unit.sv -----
// USB HID boot keyboard report decoder, top level.
// Reports enter on push/full: an item is taken when push is high and full low.
// Each full report is compared with the previously stored key slots; for each slot
// in order a release word (old key gone) and then a press word (new key) is made.
// Result words leave on empty/pop: the oldest word is on the ports while empty is
// low, and is taken when pop is high. last_event marks a report's final word.
// A front end classifies a report in its accept cycle and places the masks in a
// two-entry queue; a back end emits one word per cycle from them while the
// output is free or being taken. A report's first word passes the queue, the
// pending mask register and the output register before it shows.
// A report makes at most 2*KEY_SLOTS words; reports without events and short
// reports queue nothing. full rises when both queue entries are waiting.
// When the receiver holds pop low the output word stays, the back end stops and
// the queue fills, which then raises full.
// Reset clears the stored key slots, the queue and the output valid flag, and sets
// enter_adds_line_feed to one. The APB port holds that one register wherever paddr[2] is 0.
module boot_keyboard_report_to_key_events_unit import bkre_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        too_short,
	input  logic [7:0]  modifier_bits,
	input  logic [7:0]  key_slot_0,
	input  logic [7:0]  key_slot_1,
	input  logic [7:0]  key_slot_2,
	input  logic [7:0]  key_slot_3,
	input  logic [7:0]  key_slot_4,
	input  logic [7:0]  key_slot_5,
	output logic        empty,
	input  logic        pop,
	output logic        is_press,
	output logic [7:0]  event_key,
	output logic [7:0]  event_modifiers,
	output logic [6:0]  char_code,
	output logic        char_valid,
	output logic        line_feed_follows,
	output logic        last_event,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int EW = 18 * KEY_SLOTS + 8;
	localparam int IN_SLOTS = 6;

	logic [7:0]             in_slots [IN_SLOTS];
	logic [8*KEY_SLOTS-1:0] now_keys;
	logic                   lf_en_q;
	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [EW-1:0]          q_wdata;
	logic [EW-1:0]          q_rdata;
	logic                   out_valid;
	bkre_event_t            out_event;

	assign in_slots[0] = key_slot_0;
	assign in_slots[1] = key_slot_1;
	assign in_slots[2] = key_slot_2;
	assign in_slots[3] = key_slot_3;
	assign in_slots[4] = key_slot_4;
	assign in_slots[5] = key_slot_5;

	// Slots without an input field read as no key.
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
		if (g < IN_SLOTS) begin : g_field
			assign now_keys[8*g +: 8] = in_slots[g];
		end else begin : g_zero
			assign now_keys[8*g +: 8] = 8'h00;
		end
	end

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ENTER_LF) ? {31'b0, lf_en_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_en_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTER_LF)) begin
			lf_en_q <= pwdata[0];
		end
	end

	// Front end, queue and back end.
	bkre_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.too_short     (too_short),
		.modifier_bits (modifier_bits),
		.now_keys      (now_keys),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	bkre_fifo #(.WIDTH(EW), .DEPTH(2)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	bkre_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.lf_enable (lf_en_q),
		.out_pop   (pop && out_valid),
		.out_valid (out_valid),
		.out_event (out_event)
	);

	assign full              = q_full;
	assign empty             = !out_valid;
	assign is_press          = out_event.is_press;
	assign event_key         = out_event.key;
	assign event_modifiers   = out_event.mods;
	assign char_code         = out_event.char_code;
	assign char_valid        = out_event.char_valid;
	assign line_feed_follows = out_event.lf_follows;
	assign last_event        = out_event.last;

`ifndef ASSERT_OFF
	// The back end never takes a word from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue read while empty");

	// A line feed flag only comes with a valid carriage return press.
	a_lf_cr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_feed_follows) |-> (is_press && char_valid && char_code == CHAR_CR))
		else $error("line feed flag without carriage return press");

	// A release word carries no modifiers and no character.
	a_release_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_press) |-> (event_modifiers == 8'h00 && !char_valid && char_code == 7'h00))
		else $error("release word carries press data");
`endif

endmodule

// ----- sim/boot_keyboard_report_to_key_events_unit_tb.sv -----
// Testbench for the boot keyboard report decoder: directed reports, then keyboard-like random
// traffic, each key event word checked against an in-bench model of the slot comparison.
// Depends on bkre_pkg and boot_keyboard_report_to_key_events_unit.
`timescale 1ns / 1ps

module boot_keyboard_report_to_key_events_unit_tb;
	import bkre_pkg::*;

	localparam int          RANDOM_PER_PHASE = 22;
	localparam int          SETTLE_CYCLES    = 8;
	localparam int          HOLD_CYCLES      = 300;
	localparam int          HOLD_AFTER_WORDS = 60;
	localparam int          CYCLE_LIMIT      = 300000;
	localparam int          PREDICTED        = -1;
	localparam logic [2:0]  ADDR_ENTER_LF    = {REG_ENTER_LF, 2'b00};
	localparam logic [2:0]  ADDR_UNUSED      = 3'd4;
	localparam logic [7:0]  KEY_TABLE_LAST   = 8'h38;
	localparam logic [7:0]  KEY_ENTER        = 8'h28;

	// Characters for usage codes 0x1E to 0x38, plain and with shift held.
	localparam logic [0:26][7:0] PLAIN_SYMBOLS = {
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h0D, 8'h00, 8'h08, 8'h00, 8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C,
		8'h5C, 8'h3B, 8'h27, 8'h60, 8'h2C, 8'h2E, 8'h2F};
	localparam logic [0:26][7:0] SHIFTED_SYMBOLS = {
		8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h0D, 8'h00, 8'h00, 8'h00, 8'h20, 8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h7C,
		8'h7C, 8'h3A, 8'h22, 8'h7E, 8'h3C, 8'h3E, 8'h3F};

	typedef struct packed {
		logic            too_short;
		logic [7:0]      mods;
		logic [5:0][7:0] keys;
	} key_report_t;

	typedef struct {
		bit          cfg_write;
		bit          cfg_value;
		key_report_t rep;
		int          typed_n;
		bkre_event_t typed_ev;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        too_short = 1'b0;
	logic [7:0]  modifier_bits = 8'h00;
	logic [7:0]  key_slot_0 = 8'h00;
	logic [7:0]  key_slot_1 = 8'h00;
	logic [7:0]  key_slot_2 = 8'h00;
	logic [7:0]  key_slot_3 = 8'h00;
	logic [7:0]  key_slot_4 = 8'h00;
	logic [7:0]  key_slot_5 = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        is_press;
	logic [7:0]  event_key;
	logic [7:0]  event_modifiers;
	logic [6:0]  char_code;
	logic        char_valid;
	logic        line_feed_follows;
	logic        last_event;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Model state: stored key slots and the line feed register.
	logic [5:0][7:0] held_keys;
	logic            lf_on_enter;
	logic [5:0][7:0] typing_keys;
	bkre_event_t     expected_events[$];
	stim_row_t       directed_rows[$];
	int              mismatch_count;
	int              reports_sent;
	int              short_reports;
	int              words_checked;
	int              register_writes;
	int              cycle_count;
	bit              sender_steady;

	boot_keyboard_report_to_key_events_unit uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.too_short(too_short), .modifier_bits(modifier_bits),
		.key_slot_0(key_slot_0), .key_slot_1(key_slot_1), .key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3), .key_slot_4(key_slot_4), .key_slot_5(key_slot_5),
		.empty(empty), .pop(pop),
		.is_press(is_press), .event_key(event_key), .event_modifiers(event_modifiers),
		.char_code(char_code), .char_valid(char_valid),
		.line_feed_follows(line_feed_follows), .last_event(last_event),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// US layout character of a pressed key, zero where the map has none.
	function automatic logic [6:0] us_char(input logic [7:0] code, input logic shifted);
		int idx;
		if (code < KEY_LOWEST || code > KEY_TABLE_LAST) return 7'h00;
		if (code <= 8'h1D) return 7'((shifted ? 8'h41 : 8'h61) + code - KEY_LOWEST);
		idx = int'(code) - 'h1E;
		return shifted ? SHIFTED_SYMBOLS[idx][6:0] : PLAIN_SYMBOLS[idx][6:0];
	endfunction

	function automatic bit slots_hold(input logic [5:0][7:0] slots, input logic [7:0] code);
		foreach (slots[i]) if (slots[i] == code) return 1'b1;
		return 1'b0;
	endfunction

	// Work out the event words of one report and move it into the stored slots; short ones are skipped.
	// With keep cleared only the state advances, for rows whose words are typed in.
	function automatic void decode_report(input key_report_t rep, input bit keep);
		bkre_event_t ev;
		logic        shifted;
		int          first;
		first = expected_events.size();
		if (rep.too_short) return;
		shifted = |(rep.mods & SHIFT_MASK);
		for (int i = 0; i < 6; i++) begin
			if (held_keys[i] >= KEY_LOWEST && !slots_hold(rep.keys, held_keys[i])) begin
				ev = '0;
				ev.key = held_keys[i];
				if (keep) expected_events.push_back(ev);
			end
			if (rep.keys[i] >= KEY_LOWEST && !slots_hold(held_keys, rep.keys[i])) begin
				ev = '0;
				ev.is_press = 1'b1;
				ev.key = rep.keys[i];
				ev.mods = rep.mods;
				ev.char_code = us_char(rep.keys[i], shifted);
				ev.char_valid = ev.char_code != 7'h00;
				ev.lf_follows = ev.char_valid && ev.char_code == CHAR_CR && lf_on_enter;
				if (keep) expected_events.push_back(ev);
			end
		end
		if (expected_events.size() > first) expected_events[$].last = 1'b1;
		held_keys = rep.keys;
	endfunction

	function automatic key_report_t make_report(input logic short_flag, input logic [7:0] mods,
			input logic [7:0] k0, k1, k2, k3, k4, k5);
		key_report_t rep;
		rep.too_short = short_flag;
		rep.mods = mods;
		rep.keys = {k5, k4, k3, k2, k1, k0};
		return rep;
	endfunction

	// A key for the typing sequences: mostly table keys and Enter, now and then a release
	// or a code outside the map.
	function automatic logic [7:0] random_key();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick < 5) return 8'h00;
		if (pick < 7) return KEY_ENTER;
		if (pick < 14) return 8'($urandom_range(int'(KEY_LOWEST), int'(KEY_TABLE_LAST)));
		if (pick < 15) return 8'($urandom_range(int'(KEY_TABLE_LAST) + 1, 255));
		return 8'($urandom_range(1, 3));
	endfunction

	// Mostly a plausible next report of someone typing; some noise and some short reports.
	function automatic key_report_t random_report();
		key_report_t rep;
		int          pick;
		pick = $urandom_range(0, 99);
		rep.too_short = 1'b0;
		rep.mods = 8'($urandom);
		rep.keys = 48'({$urandom, $urandom});
		if (pick < 8) begin
			rep.too_short = 1'b1;
		end else if (pick >= 18) begin
			for (int i = 0; i < 6; i++) if ($urandom_range(0, 2) == 0) typing_keys[i] = random_key();
			rep.keys = typing_keys;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: rep.mods = 8'h00;
				6:                rep.mods = 8'h02;
				7:                rep.mods = 8'h20;
				8:                rep.mods = 8'h22;
				default:          ;
			endcase
		end
		return rep;
	endfunction

	// Idle length for either side: mostly none or short, a few long.
	function automatic int pick_gap(input bit steady);
		int pick;
		if (steady) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic add_row(input bit cfg_write, input bit cfg_value, input key_report_t rep,
			input int typed_n, input bkre_event_t typed_ev);
		stim_row_t row;
		row.cfg_write = cfg_write;
		row.cfg_value = cfg_value;
		row.rep = rep;
		row.typed_n = typed_n;
		row.typed_ev = typed_ev;
		directed_rows.push_back(row);
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endtask

	// Offer one report until it is taken, then record what it should produce.
	task automatic send_report(input key_report_t rep, input int typed_n,
			input bkre_event_t typed_ev);
		push <= 1'b1;
		too_short <= rep.too_short;
		modifier_bits <= rep.mods;
		key_slot_0 <= rep.keys[0];
		key_slot_1 <= rep.keys[1];
		key_slot_2 <= rep.keys[2];
		key_slot_3 <= rep.keys[3];
		key_slot_4 <= rep.keys[4];
		key_slot_5 <= rep.keys[5];
		@(posedge clk);
		while (full) @(posedge clk);
		decode_report(rep, typed_n == PREDICTED);
		if (typed_n > 0) expected_events.push_back(typed_ev);
		reports_sent++;
		if (rep.too_short) short_reports++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			push <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Let the block drain before touching its register.
	task automatic settle_block();
		push <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ENTER_LF) lf_on_enter = data[0];
		register_writes++;
	endtask

	// Compare the word taken at this edge with the oldest expectation.
	task automatic check_event();
		bkre_event_t got;
		bkre_event_t want;
		got = {is_press, event_key, event_modifiers, char_code, char_valid,
			line_feed_follows, last_event};
		words_checked++;
		if (expected_events.size() == 0) begin
			flag_error($sformatf("unexpected word press=%0b key=%h", got.is_press, got.key));
		end else begin
			want = expected_events.pop_front();
			if (got !== want) flag_error($sformatf(
				"press %0b/%0b key %h/%h mods %h/%h char %h/%h valid %0b/%0b lf %0b/%0b last %0b/%0b",
				want.is_press, got.is_press, want.key, got.key, want.mods, got.mods,
				want.char_code, got.char_code, want.char_valid, got.char_valid,
				want.lf_follows, got.lf_follows, want.last, got.last));
		end
	endtask

	// Result side: take words with random stalls and one long hold that backs the block up.
	initial begin : word_sink
		int stall_left;
		bit held_off;
		bit steady;
		stall_left = 0;
		held_off = 1'b0;
		steady = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) check_event();
			if (cycle_count % 64 == 0) steady = $urandom_range(0, 2) == 0;
			if (!held_off && words_checked >= HOLD_AFTER_WORDS) begin
				held_off = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall_left = pick_gap(steady);
			end
		end
	end

	// Run limit.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d words still expected",
			cycle_count, expected_events.size());
		$display("[boot_keyboard_report_to_key_events_unit] ERROR");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, drain and verdict.
	initial begin : stimulus
		bkre_event_t first_a;
		held_keys = '0;
		typing_keys = '0;
		lf_on_enter = 1'b1;
		mismatch_count = 0;
		reports_sent = 0;
		short_reports = 0;
		words_checked = 0;
		register_writes = 0;
		sender_steady = 1'b0;

		first_a = '{is_press: 1'b1, key: 8'h04, mods: 8'h00, char_code: 7'h61,
			char_valid: 1'b1, lf_follows: 1'b0, last: 1'b1};

		// Short report at reset, then the first press and a modifier-only change.
		add_row(0, 0, make_report(1, 8'hFF, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0);
		add_row(0, 0, make_report(0, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, first_a);
		add_row(0, 0, make_report(0, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
		// Enter with the line feed on, then every bit high, then all released.
		add_row(0, 0, make_report(0, 8'h00, KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);
		// Reserved codes never make a word; a short report leaves the stored slots alone.
		add_row(0, 0, make_report(0, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00), 0, '0);
		add_row(0, 0, make_report(1, 8'h00, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15), 0, '0);
		add_row(0, 0, make_report(0, 8'h00, 8'h03, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00), 0, '0);
		// Full slot turnover gives the most words; then the rest of the map, both columns.
		add_row(0, 0, make_report(0, 8'h20, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h22, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h20, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h00, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2C, 8'h2D),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h02, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h33),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'hDD, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h2A),
			PREDICTED, '0);
		// Map holes (escape, tab, shifted delete) and a code past the map.
		add_row(0, 0, make_report(0, 8'h22, 8'h29, 8'h2B, 8'h2A, 8'h39, 8'h38, 8'h1D),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h22, KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);
		// Line feed off: Enter must not ask for one; high codes are passed through.
		add_row(1, 0, make_report(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h00, KEY_ENTER, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h40),
			PREDICTED, '0);
		add_row(1, 1, make_report(0, 8'h55, 8'h00, KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);
		add_row(0, 0, make_report(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
			PREDICTED, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg_write) begin
				settle_block();
				write_register(ADDR_ENTER_LF, {31'd0, directed_rows[i].cfg_value});
			end
			send_report(directed_rows[i].rep, directed_rows[i].typed_n, directed_rows[i].typed_ev);
			idle_sender(pick_gap(1'b0));
		end

		// Random typing in four phases; the register is written between them.
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 1) begin
				settle_block();
				write_register(ADDR_ENTER_LF, 32'd0);
			end else if (phase == 2) begin
				// A write to an address with no register must change nothing.
				settle_block();
				write_register(ADDR_UNUSED, 32'hFFFF_FFFF);
			end else if (phase == 3) begin
				settle_block();
				write_register(ADDR_ENTER_LF, 32'd1);
			end
			sender_steady = phase % 2 == 1;
			repeat (RANDOM_PER_PHASE) begin
				send_report(random_report(), PREDICTED, '0);
				idle_sender(pick_gap(sender_steady));
			end
		end

		settle_block();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d reports (%0d short) and checked %0d event words over %0d register writes,",
			reports_sent, short_reports, words_checked, register_writes);
		$display("with random stalls on both sides and one %0d-cycle output hold.", HOLD_CYCLES);
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("[boot_keyboard_report_to_key_events_unit] OK");
		end else begin
			$display("%0d mismatches, %0d words never arrived", mismatch_count,
				expected_events.size());
			$display("[boot_keyboard_report_to_key_events_unit] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/bkre_pkg.sv
rtl/core/bkre_front.sv
rtl/core/bkre_fifo.sv
rtl/core/bkre_back.sv
rtl/core/boot_keyboard_report_to_key_events_unit.sv
sim/boot_keyboard_report_to_key_events_unit_tb.sv
